>>> sv/sensor_frame_crc_convert_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensor frame CRC convert core
// Checks are compiled in simulation and drop out of synthesis.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CRC_CONVERT_CORE_MACROS_SVH
`define SENSOR_FRAME_CRC_CONVERT_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define SFCC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sfcc assertion failed");
// expression must never be true
`define SFCC_ASSERT_NEVER(lbl, expr) \
    `SFCC_ASSERT(lbl, !(expr))
`else
`define SFCC_ASSERT(lbl, prop)
`define SFCC_ASSERT_NEVER(lbl, expr)
`endif

`endif

>>> sv/sfcc_pkg.sv
// ----------------------------------------------------------------------------
// sfcc_pkg
// Types and constants shared by the frame converter modules, and the CRC-8 step used by the intake.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcc_pkg;

    localparam logic [7:0] CRC_POLY   = 8'h31;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] CRC_TOPBIT = 8'h80;

    localparam logic [12:0] T_MUL    = 13'd4375;
    localparam int          T_SHIFT  = 14;
    localparam logic [15:0] T_OFFSET = 16'd4500;
    localparam logic [9:0]  H_MUL    = 10'd625;
    localparam int          H_SHIFT  = 12;

    localparam int TEMP_W = 15;
    localparam int HUM_W  = 14;

    // byte positions within a frame
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        logic        temp_ok;
        logic        hum_ok;
    } frame_t;

    typedef struct packed {
        logic               full;
        logic               empty;
    } fifo_stat_t;

    // one byte through CRC-8, MSB first
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOPBIT) != 8'h00)
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/sensor_frame_crc_convert_core.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_convert_core
// Six-byte humidity/temperature frame checker and converter.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle while s_tready is high (temp hi, temp lo,
// temp CRC, hum hi, hum lo, hum CRC; CRC-8 poly 0x31, init 0xFF); the record
// built on the sixth byte passes the queue and the conversion register, which
// presents temperature in 0.01 C and humidity in 0.01 %RH with the CRC flags;
// values go out even when a check fails. s_tuser high restarts the frame at
// the current byte. A two-record queue between intake and conversion register
// absorbs output stalls; s_tready drops only while it holds two unread frames.
`default_nettype none

`include "sensor_frame_crc_convert_core_macros.svh"

module sensor_frame_crc_convert_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
    output logic [2:0]       m_tuser    // [0] temp_crc_ok, [1] hum_crc_ok, [2] frame_ok
);

    sfcc_pkg::fifo_stat_t fifo_stat;
    sfcc_pkg::frame_t     push_data;
    sfcc_pkg::frame_t     pop_data;
    logic                 push;
    logic                 pop;

    sfcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_data (push_data)
    );

    sfcc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (fifo_stat)
    );

    sfcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_stat (fifo_stat),
        .pop_data  (pop_data),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // a completed frame must never meet a full queue
    `SFCC_ASSERT_NEVER(a_push_when_full, push && fifo_stat.full)
    `SFCC_ASSERT(a_frame_ok_flags, m_tvalid |-> (m_tuser[2] == (m_tuser[0] & m_tuser[1])))
    `SFCC_ASSERT(a_hum_range, m_tvalid |-> (m_tdata[28:15] <= 14'd9999))

endmodule

`default_nettype wire

>>> sv/sfcc_front.sv
// ----------------------------------------------------------------------------
// sfcc_front
// Byte intake: tracks frame position, runs the CRC checks and pushes one
// raw frame record into the queue on the sixth byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcc_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // data_byte
    input  wire logic                s_tuser,   // frame_start
    input  wire sfcc_pkg::fifo_stat_t fifo_stat,
    output logic                     push,
    output sfcc_pkg::frame_t         push_data
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  high_reg, high_next;
    logic [15:0] temp_raw_reg, temp_raw_next;
    logic [15:0] hum_raw_reg, hum_raw_next;
    logic        temp_ok_reg, temp_ok_next;
    logic        accept;
    logic [2:0]  pos_eff;

    assign s_tready = !fifo_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign pos_eff  = s_tuser ? sfcc_pkg::POS_T_HI : pos_reg;

    always_comb
    begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        high_next     = high_reg;
        temp_raw_next = temp_raw_reg;
        hum_raw_next  = hum_raw_reg;
        temp_ok_next  = temp_ok_reg;
        push          = 1'b0;
        if (accept)
        begin
            pos_next = (pos_eff == sfcc_pkg::POS_H_CRC) ? sfcc_pkg::POS_T_HI
                                                        : pos_eff + 3'd1;
            unique case (pos_eff)
                sfcc_pkg::POS_T_HI, sfcc_pkg::POS_H_HI:
                begin
                    crc_next  = sfcc_pkg::crc8_feed(sfcc_pkg::CRC_INIT, s_tdata);
                    high_next = s_tdata;
                end
                sfcc_pkg::POS_T_LO:
                begin
                    crc_next      = sfcc_pkg::crc8_feed(crc_reg, s_tdata);
                    temp_raw_next = {high_reg, s_tdata};
                end
                sfcc_pkg::POS_T_CRC:
                begin
                    temp_ok_next = (s_tdata == crc_reg);
                    crc_next     = sfcc_pkg::CRC_INIT;
                end
                sfcc_pkg::POS_H_LO:
                begin
                    crc_next     = sfcc_pkg::crc8_feed(crc_reg, s_tdata);
                    hum_raw_next = {high_reg, s_tdata};
                end
                sfcc_pkg::POS_H_CRC:
                begin
                    crc_next = sfcc_pkg::CRC_INIT;
                    push     = 1'b1;
                end
                default:
                begin
                    pos_next = sfcc_pkg::POS_T_HI;
                end
            endcase
        end
    end

    assign push_data.temp_raw = temp_raw_reg;
    assign push_data.hum_raw  = hum_raw_reg;
    assign push_data.temp_ok  = temp_ok_reg;
    assign push_data.hum_ok   = (s_tdata == crc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= sfcc_pkg::POS_T_HI;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // words are always written before the sixth byte reads them
    always_ff @(posedge clk)
    begin
        crc_reg      <= crc_next;
        high_reg     <= high_next;
        temp_raw_reg <= temp_raw_next;
        hum_raw_reg  <= hum_raw_next;
        temp_ok_reg  <= temp_ok_next;
    end

endmodule

`default_nettype wire

>>> sv/sfcc_fifo.sv
// ----------------------------------------------------------------------------
// sfcc_fifo
// Short register queue of raw frame records between intake and conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcc_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire sfcc_pkg::frame_t    push_data,
    input  wire logic                pop,
    output sfcc_pkg::frame_t         pop_data,
    output sfcc_pkg::fifo_stat_t     stat
);

    sfcc_pkg::frame_t                 mem_reg [sfcc_pkg::FIFO_DEPTH];
    logic [sfcc_pkg::FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [sfcc_pkg::FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [sfcc_pkg::FIFO_AW:0]       count_reg, count_next;
    logic                             do_push, do_pop;

    localparam logic [sfcc_pkg::FIFO_AW:0] DEPTH_C = (sfcc_pkg::FIFO_AW+1)'(sfcc_pkg::FIFO_DEPTH);
    localparam logic [sfcc_pkg::FIFO_AW-1:0] LAST_C =
        sfcc_pkg::FIFO_AW'(sfcc_pkg::FIFO_DEPTH - 1);

    assign stat.full  = (count_reg == DEPTH_C);
    assign stat.empty = (count_reg == '0);

    assign do_push  = push && !stat.full;
    assign do_pop   = pop && !stat.empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

>>> sv/sfcc_back.sv
// ----------------------------------------------------------------------------
// sfcc_back
// Conversion stage: scales raw words to centi-units and holds the result
// in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcc_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sfcc_pkg::fifo_stat_t fifo_stat,
    input  wire sfcc_pkg::frame_t    pop_data,
    output logic                     pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [31:0]              m_tdata,   // temperature_centi, humidity_centi, pad
    output logic [2:0]               m_tuser    // temp_crc_ok, hum_crc_ok, frame_ok
);

    logic                        valid_reg, valid_next;
    logic [sfcc_pkg::TEMP_W-1:0] temp_reg, temp_next;
    logic [sfcc_pkg::HUM_W-1:0]  hum_reg, hum_next;
    logic [2:0]                  flags_reg, flags_next;
    logic                        load;
    logic [28:0]                 t_prod;
    logic [25:0]                 h_prod;
    logic [15:0]                 t_scaled;
    logic [15:0]                 t_centi;

    assign load = !valid_reg || m_tready;
    assign pop  = load && !fifo_stat.empty;

    assign t_prod   = 29'(sfcc_pkg::T_MUL) * 29'(pop_data.temp_raw);
    assign h_prod   = 26'(sfcc_pkg::H_MUL) * 26'(pop_data.hum_raw);
    assign t_scaled = 16'(t_prod >> sfcc_pkg::T_SHIFT);
    assign t_centi  = t_scaled - sfcc_pkg::T_OFFSET;

    always_comb
    begin
        valid_next = valid_reg;
        temp_next  = temp_reg;
        hum_next   = hum_reg;
        flags_next = flags_reg;
        if (load)
        begin
            valid_next = !fifo_stat.empty;
            if (!fifo_stat.empty)
            begin
                temp_next  = t_centi[sfcc_pkg::TEMP_W-1:0];
                hum_next   = sfcc_pkg::HUM_W'(h_prod >> sfcc_pkg::H_SHIFT);
                flags_next = {pop_data.temp_ok & pop_data.hum_ok,
                              pop_data.hum_ok, pop_data.temp_ok};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        temp_reg  <= temp_next;
        hum_reg   <= hum_next;
        flags_reg <= flags_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, hum_reg, temp_reg};
    assign m_tuser  = flags_reg;

endmodule

`default_nettype wire

>>> verif/sfcc_frame_checker.sv
// ----------------------------------------------------------------------------
// sfcc_frame_checker
// Watches both streams of the frame converter, predicts each reading from
// the accepted bytes and compares it field by field with what comes out.
// ----------------------------------------------------------------------------

package sfcc_tb_pkg;

    import sfcc_pkg::*;

    // one byte into CRC-8, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8)
            r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        return r;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

endpackage

module sfcc_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfcc_pkg::*;
    import sfcc_tb_pkg::*;

    typedef struct packed {
        logic [14:0] temp_centi;
        logic [13:0] hum_centi;
        logic        temp_ok;
        logic        hum_ok;
        logic        frame_ok;
    } reading_t;

    reading_t readings_due[$];

    // converter state as seen from the byte stream
    logic [2:0]  byte_pos;
    logic [7:0]  word_crc_acc;
    logic [7:0]  hi_byte;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        temp_good;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d (0x%0h), got %0d (0x%0h)", name, want, want, got, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        logic [2:0]  slot;
        logic [31:0] scaled;
        logic        hum_good;
        reading_t    want;

        if (!rst_n)
        begin
            byte_pos     = POS_T_HI;
            word_crc_acc = CRC_INIT;
            hi_byte      = '0;
            temp_word    = '0;
            hum_word     = '0;
            temp_good    = 1'b0;
            readings_due.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                slot = s_tuser ? POS_T_HI : byte_pos;
                case (slot)
                    POS_T_HI, POS_H_HI:
                    begin
                        word_crc_acc = crc8_step(CRC_INIT, s_tdata);
                        hi_byte      = s_tdata;
                    end
                    POS_T_LO:
                    begin
                        word_crc_acc = crc8_step(word_crc_acc, s_tdata);
                        temp_word    = {hi_byte, s_tdata};
                    end
                    POS_T_CRC:
                    begin
                        temp_good    = (s_tdata == word_crc_acc);
                        word_crc_acc = CRC_INIT;
                    end
                    POS_H_LO:
                    begin
                        word_crc_acc = crc8_step(word_crc_acc, s_tdata);
                        hum_word     = {hi_byte, s_tdata};
                    end
                    default:
                    begin
                        hum_good        = (s_tdata == word_crc_acc);
                        scaled          = T_MUL * temp_word;
                        scaled          = (scaled >> T_SHIFT) - T_OFFSET;
                        want.temp_centi = scaled[14:0];
                        scaled          = H_MUL * hum_word;
                        scaled          = scaled >> H_SHIFT;
                        want.hum_centi  = scaled[13:0];
                        want.temp_ok    = temp_good;
                        want.hum_ok     = hum_good;
                        want.frame_ok   = temp_good & hum_good;
                        readings_due.push_back(want);
                        word_crc_acc    = CRC_INIT;
                    end
                endcase
                byte_pos = (slot == POS_H_CRC) ? POS_T_HI : slot + 3'd1;
            end

            if (m_tvalid && m_tready)
            begin
                if (readings_due.size() == 0)
                begin
                    $error("result with none expected: tdata 0x%0h tuser 0x%0h",
                           m_tdata, m_tuser);
                    errors++;
                end
                else
                begin
                    want = readings_due.pop_front();
                    check_field("temperature_centi", want.temp_centi, m_tdata[14:0]);
                    check_field("humidity_centi", want.hum_centi, m_tdata[28:15]);
                    check_field("tdata padding", 0, m_tdata[31:29]);
                    check_field("temp_crc_ok", want.temp_ok, m_tuser[0]);
                    check_field("hum_crc_ok", want.hum_ok, m_tuser[1]);
                    check_field("frame_ok", want.frame_ok, m_tuser[2]);
                end
            end
        end
        pending <= readings_due.size();
    end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives measurement frames into the frame converter with random idling on
// both streams; the checker module predicts and compares every reading.
// ----------------------------------------------------------------------------

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sfcc_pkg::*;
    import sfcc_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 250;
    localparam int DRAIN_CYCLES  = 10;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [31:0] m_tdata;
    wire  [2:0]  m_tuser;

    int errors;
    int pending;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int bytes_sent  = 0;
    int cycle_count = 0;

    always #5 clk = ~clk;

    sensor_frame_crc_convert_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sfcc_frame_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("sensor_frame_crc_convert_core: mismatch");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic start);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    // bad_t / bad_h flip the matching CRC byte by a nonzero pattern
    task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                              input logic mark, input logic bad_t, input logic bad_h);
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        t_crc = word_crc(t_word) ^ (bad_t ? 8'($urandom_range(255, 1)) : 8'h00);
        h_crc = word_crc(h_word) ^ (bad_h ? 8'($urandom_range(255, 1)) : 8'h00);
        send_byte(t_word[15:8], mark);
        send_byte(t_word[7:0], 1'b0);
        send_byte(t_crc, 1'b0);
        send_byte(h_word[15:8], 1'b0);
        send_byte(h_word[7:0], 1'b0);
        send_byte(h_crc, 1'b0);
    endtask

    task automatic random_traffic(input int items);
        int stop_at;
        int n;
        stop_at = bytes_sent + items;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(99) < 85)
                send_frame(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                           $urandom_range(3) != 0, $urandom_range(3) == 0,
                           $urandom_range(3) == 0);
            else
            begin
                // stray bytes, sometimes marked as a frame start
                n = $urandom_range(7, 1);
                repeat (n)
                    send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lowest and highest words, good and bad CRCs
        send_frame(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
        // unmarked frame right after a complete one, temperature CRC broken
        send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0);
        // partial frame thrown away by a new start mark
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b1);
        send_frame(16'h6666, 16'h0001, 1'b1, 1'b1, 1'b1);

        gap_pct   = 36;
        stall_pct = 69;
        random_traffic(PHASE_ITEMS);
        gap_pct   = 69;
        stall_pct = 36;
        random_traffic(PHASE_ITEMS);
        gap_pct   = 0;
        stall_pct = 0;
        random_traffic(PHASE_ITEMS);

        s_tvalid <= 1'b0;
        s_tuser  <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("sensor_frame_crc_convert_core: match");
        else
            $display("sensor_frame_crc_convert_core: mismatch");
        $finish;
    end

endmodule
